// ----- design/pet_pkg.sv -----
// Shared types and constants for the pending echo tracker.
// Holds table sizing, item structs, operation/event codes and FSM states.
// No dependencies.
package pet_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SCAN_W = IDX_W + 1;
	localparam int RM_W = 5;

	localparam logic [15:0] REQ_ALL = 16'hFFFF;
	localparam logic [31:0] RTT_NONE = 32'hFFFF_FFFF;
	localparam logic [RM_W-1:0] RM_MAX = '1;

	typedef logic [IDX_W-1:0] pet_idx_t;
	typedef logic [CNT_W-1:0] pet_cnt_t;
	typedef pet_idx_t [TABLE_DEPTH-1:0] pet_age_vec_t;

	typedef enum logic [1:0] {
		FN_START  = 2'd0,
		FN_REPLY  = 2'd1,
		FN_TICK   = 2'd2,
		FN_CANCEL = 2'd3
	} pet_func_t;

	typedef enum logic [2:0] {
		EV_STARTED   = 3'd0,
		EV_FULL      = 3'd1,
		EV_REPLIED   = 3'd2,
		EV_UNMATCHED = 3'd3,
		EV_TIMED_OUT = 3'd4,
		EV_IDLE_TICK = 3'd5,
		EV_CANCELLED = 3'd6
	} pet_evt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FINISH,
		ST_DONE
	} pet_state_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         owner;
		logic signed [15:0] req_id;
		logic [21:0]        timeout_ms;
		logic [31:0]        now_ms;
		logic [15:0]        reply_seq;
	} pet_in_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [7:0]         out_owner;
		logic [14:0]        out_req_id;
		logic [15:0]        out_seq;
		logic signed [31:0] rtt_ms;
		logic [RM_W-1:0]    removed_count;
	} pet_out_t;

	typedef struct packed {
		logic [7:0]  owner;
		logic [14:0] req_id;
		logic [15:0] seq;
		logic [31:0] start_ms;
		logic [21:0] timeout_ms;
	} pet_entry_t;

	// insert / remove requests to the slot order tracker
	typedef struct packed {
		logic     ins_en;
		pet_idx_t ins_idx;
		logic     rm_en;
		pet_idx_t rm_idx;
	} pet_ord_cmd_t;

endpackage

// ----- design/pet_slot_mem.sv -----
// Slot payload memory: one write port, one registered read port.
// Depends on pet_pkg.
module pet_slot_mem (
	input  logic                 clk,
	input  logic                 wr_en,
	input  pet_pkg::pet_idx_t    wr_addr,
	input  pet_pkg::pet_entry_t  wr_data,
	input  logic                 rd_en,
	input  pet_pkg::pet_idx_t    rd_addr,
	output pet_pkg::pet_entry_t  rd_data
);
	import pet_pkg::*;

	pet_entry_t mem_q [TABLE_DEPTH];
	pet_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/pet_order.sv -----
// Slot occupancy and age ranks (rank 0 = oldest), plus lowest free slot.
// Depends on pet_pkg.
module pet_order (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pet_pkg::pet_ord_cmd_t       cmd,
	output logic [pet_pkg::TABLE_DEPTH-1:0] valid,
	output pet_pkg::pet_age_vec_t       ages,
	output pet_pkg::pet_idx_t           free_idx,
	output logic                        full
);
	import pet_pkg::*;

	logic [TABLE_DEPTH-1:0] valid_q;
	pet_age_vec_t           age_q;
	pet_cnt_t               cnt_q;
	pet_idx_t               rm_age;

	assign rm_age = age_q[cmd.rm_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (cmd.ins_en) begin
				valid_q[cmd.ins_idx] <= 1'b1;
				cnt_q                <= cnt_q + 1'b1;
			end else if (cmd.rm_en) begin
				valid_q[cmd.rm_idx] <= 1'b0;
				cnt_q               <= cnt_q - 1'b1;
			end
		end
	end

	// rank a new slot after the live ones; close the gap left by a removed rank
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			age_q[cmd.ins_idx] <= cnt_q[IDX_W-1:0];
		end else if (cmd.rm_en) begin
			for (int j = 0; j < TABLE_DEPTH; j++) begin
				if (valid_q[j] && (age_q[j] > rm_age)) begin
					age_q[j] <= age_q[j] - 1'b1;
				end
			end
		end
	end

	always_comb begin
		free_idx = '0;
		for (int j = TABLE_DEPTH - 1; j >= 0; j--) begin
			if (!valid_q[j]) begin
				free_idx = IDX_W'(j);
			end
		end
	end

	assign full  = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign valid = valid_q;
	assign ages  = age_q;

endmodule

// ----- design/pending_echo_tracker_top.sv -----
// Outstanding echo request table with timeouts.
// Start item: result computed in ST_START, then passed to the output register in ST_DONE.
// Reply, tick, cancel: one memory read per slot in ST_SCAN, then ST_FINISH and ST_DONE.
// One item in work at a time: the next is accepted only after ST_DONE returns to ST_IDLE.
// The result register holds a finished item while the next one is accepted.
// arst_n clears FSM, valid bits, counts and sequence counter; payload is not reset.
module pending_echo_tracker_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pet_pkg::pet_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output pet_pkg::pet_out_t out_data
);
	import pet_pkg::*;

	pet_state_t   state_q, state_d;
	pet_in_t      in_q;
	logic [SCAN_W-1:0] scan_q;
	logic         vld_s1;
	pet_idx_t     idx_s1;
	logic         best_found_q;
	pet_idx_t     best_idx_q;
	pet_idx_t     best_age_q;
	pet_entry_t   best_ent_q;
	logic [31:0]  best_el_q;
	logic [RM_W-1:0] rm_cnt_q;
	logic [15:0]  seq_q;
	pet_out_t     res_q, res_d;
	pet_out_t     out_q;
	logic         out_valid_q;

	logic         rd_en;
	pet_idx_t     rd_addr;
	pet_entry_t   rd_data;
	logic         wr_en;
	pet_entry_t   wr_data;
	pet_ord_cmd_t ord_cmd;
	logic [TABLE_DEPTH-1:0] slot_valid;
	pet_age_vec_t ages;
	pet_idx_t     free_idx;
	logic         full;
	logic         res_load;
	logic         out_free;

	logic [31:0]  elapsed;
	logic         slot_v;
	pet_idx_t     slot_age;
	logic         tmo_hit;
	logic         seq_hit;
	logic         better;
	logic         cxl_hit;
	logic [15:0]  seq_next;

	pet_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (free_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pet_order u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ord_cmd),
		.valid    (slot_valid),
		.ages     (ages),
		.free_idx (free_idx),
		.full     (full)
	);

	// slot evaluation on the data returned by the memory
	assign elapsed  = in_q.now_ms - rd_data.start_ms;
	assign slot_v   = vld_s1 && slot_valid[idx_s1];
	assign slot_age = ages[idx_s1];
	assign tmo_hit  = (rd_data.timeout_ms != '0) && !elapsed[31] &&
			  (elapsed >= {10'd0, rd_data.timeout_ms});
	assign seq_hit  = (rd_data.seq == in_q.reply_seq);
	assign better   = slot_v &&
			  (((in_q.func == FN_REPLY) && seq_hit) ||
			   ((in_q.func == FN_TICK) && tmo_hit)) &&
			  (!best_found_q || (slot_age < best_age_q));
	assign cxl_hit  = slot_v && (in_q.func == FN_CANCEL) &&
			  (rd_data.owner == in_q.owner) &&
			  (($unsigned(in_q.req_id) == REQ_ALL) ||
			   (rd_data.req_id == in_q.req_id[14:0]));
	assign seq_next = seq_q + 16'd1;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.func == FN_START) ? ST_START : ST_SCAN;
				end
			end
			ST_START: begin
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (scan_q == SCAN_W'(TABLE_DEPTH)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// per-state outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = scan_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_data  = '{owner: in_q.owner, req_id: in_q.req_id[14:0], seq: seq_next,
			     start_ms: in_q.now_ms, timeout_ms: in_q.timeout_ms};
		ord_cmd  = '{ins_en: 1'b0, ins_idx: free_idx, rm_en: 1'b0, rm_idx: idx_s1};
		res_load = 1'b0;
		res_d    = '{event_res: EV_CANCELLED, out_owner: in_q.owner,
			     out_req_id: in_q.req_id[14:0], out_seq: 16'd0,
			     rtt_ms: RTT_NONE, removed_count: rm_cnt_q};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_START: begin
				res_load = 1'b1;
				if (full) begin
					res_d.event_res = EV_FULL;
				end else begin
					wr_en          = 1'b1;
					ord_cmd.ins_en = 1'b1;
					res_d.event_res = EV_STARTED;
					res_d.out_seq   = seq_next;
				end
			end
			ST_SCAN: begin
				rd_en         = (scan_q < SCAN_W'(TABLE_DEPTH));
				ord_cmd.rm_en = cxl_hit;
			end
			ST_FINISH: begin
				res_load       = 1'b1;
				ord_cmd.rm_en  = best_found_q && (in_q.func != FN_CANCEL);
				ord_cmd.rm_idx = best_idx_q;
				case (in_q.func)
					FN_REPLY: begin
						if (best_found_q) begin
							res_d = '{event_res: EV_REPLIED,
								  out_owner: best_ent_q.owner,
								  out_req_id: best_ent_q.req_id,
								  out_seq: best_ent_q.seq,
								  rtt_ms: best_el_q, removed_count: '0};
						end else begin
							res_d = '{event_res: EV_UNMATCHED, out_owner: 8'd0,
								  out_req_id: 15'd0, out_seq: in_q.reply_seq,
								  rtt_ms: RTT_NONE, removed_count: '0};
						end
					end
					FN_TICK: begin
						if (best_found_q) begin
							res_d = '{event_res: EV_TIMED_OUT,
								  out_owner: best_ent_q.owner,
								  out_req_id: best_ent_q.req_id,
								  out_seq: best_ent_q.seq,
								  rtt_ms: RTT_NONE, removed_count: '0};
						end else begin
							res_d = '{event_res: EV_IDLE_TICK, out_owner: 8'd0,
								  out_req_id: 15'd0, out_seq: 16'd0,
								  rtt_ms: RTT_NONE, removed_count: '0};
						end
					end
					default: begin
						res_d.event_res = EV_CANCELLED;
					end
				endcase
			end
			ST_DONE: begin
				res_load = 1'b0;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vld_s1       <= 1'b0;
			scan_q       <= '0;
			best_found_q <= 1'b0;
			rm_cnt_q     <= '0;
			seq_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (state_q == ST_IDLE) begin
				scan_q       <= '0;
				best_found_q <= 1'b0;
				rm_cnt_q     <= '0;
			end else if (state_q == ST_SCAN) begin
				if (rd_en) begin
					scan_q <= scan_q + 1'b1;
				end else begin
					scan_q <= SCAN_W'(TABLE_DEPTH);
				end
				if (better) begin
					best_found_q <= 1'b1;
				end
				if (cxl_hit && (rm_cnt_q != RM_MAX)) begin
					rm_cnt_q <= rm_cnt_q + 1'b1;
				end
			end
			if (ord_cmd.ins_en) begin
				seq_q <= seq_next;
			end
			if (state_q == ST_DONE) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the stage-1 index and the winning entry carry no reset
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		if ((state_q == ST_IDLE) && in_valid) begin
			in_q <= in_data;
		end
		if ((state_q == ST_SCAN) && better) begin
			best_idx_q <= idx_s1;
			best_age_q <= slot_age;
			best_ent_q <= rd_data;
			best_el_q  <= elapsed;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/pet_checker.sv -----
// Port-level checks for pending_echo_tracker_top, bound to the top level.
// Depends on pet_pkg.
module pet_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input pet_pkg::pet_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input pet_pkg::pet_out_t out_data
);
	import pet_pkg::*;

	// a waiting input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item still in work");

	a_rtt_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res != EV_REPLIED) |->
		($unsigned(out_data.rtt_ms) == RTT_NONE))
		else $error("rtt set on a non-reply result");

	a_count_cancel_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res != EV_CANCELLED) |->
		(out_data.removed_count == '0))
		else $error("removed count set on a non-cancel result");

endmodule

bind pending_echo_tracker_top pet_checker u_pet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- bench/pending_echo_tracker_top_tb.sv -----
// Self-checking bench for pending_echo_tracker_top: directed table, a random mix, then emptying the table.
// Keeps its own copy of the slot table to predict each result item.
// Depends on pet_pkg and the top-level RTL only.
`timescale 1ns / 100ps

module pending_echo_tracker_top_tb;
	import pet_pkg::*;

	localparam int N_RANDOM = 770;

	typedef struct {
		pet_in_t  stim;
		bit       typed;
		pet_out_t want;
	} echo_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	pet_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pet_out_t out_data;

	bit       idle_on = 1'b1;
	int       mismatches = 0;
	int       n_checked = 0;
	int       n_sent = 0;
	int       ev_seen[8];
	pet_out_t echo_results_due[$];
	echo_row_t dir_rows[$];

	// shadow of the slot table
	bit        slot_used[TABLE_DEPTH];
	bit [7:0]  tab_owner[TABLE_DEPTH];
	bit [14:0] tab_rid[TABLE_DEPTH];
	bit [15:0] tab_seq[TABLE_DEPTH];
	bit [31:0] tab_start[TABLE_DEPTH];
	bit [21:0] tab_tmo[TABLE_DEPTH];
	int        tab_rank[TABLE_DEPTH];
	bit [15:0] seq_ctr = '0;

	pending_echo_tracker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic pet_in_t mk_in(pet_func_t f, bit [7:0] own, bit [15:0] rid,
			bit [21:0] tmo, bit [31:0] now, bit [15:0] rseq);
		pet_in_t it;
		it.func = f;
		it.owner = own;
		it.req_id = rid;
		it.timeout_ms = tmo;
		it.now_ms = now;
		it.reply_seq = rseq;
		return it;
	endfunction

	function automatic pet_out_t mk_out(pet_evt_t ev, bit [7:0] own, bit [14:0] rid,
			bit [15:0] seq, bit [31:0] rtt, bit [RM_W-1:0] cnt);
		pet_out_t o;
		o.event_res = ev;
		o.out_owner = own;
		o.out_req_id = rid;
		o.out_seq = seq;
		o.rtt_ms = rtt;
		o.removed_count = cnt;
		return o;
	endfunction

	function automatic void drop_slot(int s);
		slot_used[s] = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (slot_used[i] && tab_rank[i] > tab_rank[s])
				tab_rank[i]--;
	endfunction

	function automatic int pick_live();
		int idx[$];
		foreach (slot_used[i])
			if (slot_used[i])
				idx.insert(idx.size(), i);
		if (idx.size() == 0)
			return -1;
		return idx[$urandom_range(0, idx.size() - 1)];
	endfunction

	// Applies one item to the shadow table and returns the result it causes.
	function automatic pet_out_t echo_table_step(pet_in_t it);
		int        hit = -1;
		int        free_idx = -1;
		int        n_live = 0;
		bit [31:0] el;
		bit        all;
		bit [RM_W-1:0] removed = '0;
		pet_out_t  res;
		case (it.func)
			FN_START: begin
				foreach (slot_used[i]) begin
					if (slot_used[i])
						n_live++;
					else if (free_idx < 0)
						free_idx = i;
				end
				if (free_idx < 0)
					return mk_out(EV_FULL, it.owner, it.req_id[14:0], '0, RTT_NONE, '0);
				seq_ctr++;
				slot_used[free_idx] = 1'b1;
				tab_owner[free_idx] = it.owner;
				tab_rid[free_idx] = it.req_id[14:0];
				tab_seq[free_idx] = seq_ctr;
				tab_start[free_idx] = it.now_ms;
				tab_tmo[free_idx] = it.timeout_ms;
				tab_rank[free_idx] = n_live;
				res = mk_out(EV_STARTED, it.owner, it.req_id[14:0], seq_ctr, RTT_NONE, '0);
			end
			FN_REPLY: begin
				foreach (slot_used[i])
					if (slot_used[i] && tab_seq[i] == it.reply_seq &&
							(hit < 0 || tab_rank[i] < tab_rank[hit]))
						hit = i;
				if (hit < 0)
					return mk_out(EV_UNMATCHED, '0, '0, it.reply_seq, RTT_NONE, '0);
				res = mk_out(EV_REPLIED, tab_owner[hit], tab_rid[hit], tab_seq[hit],
					it.now_ms - tab_start[hit], '0);
				drop_slot(hit);
			end
			FN_TICK: begin
				foreach (slot_used[i]) begin
					el = it.now_ms - tab_start[i];
					// negative elapsed time (start in the future) never expires
					if (slot_used[i] && tab_tmo[i] != 0 && !el[31] && el >= tab_tmo[i] &&
							(hit < 0 || tab_rank[i] < tab_rank[hit]))
						hit = i;
				end
				if (hit < 0)
					return mk_out(EV_IDLE_TICK, '0, '0, '0, RTT_NONE, '0);
				res = mk_out(EV_TIMED_OUT, tab_owner[hit], tab_rid[hit], tab_seq[hit],
					RTT_NONE, '0);
				drop_slot(hit);
			end
			default: begin
				all = (it.req_id == REQ_ALL);
				for (int i = 0; i < TABLE_DEPTH; i++)
					if (slot_used[i] && tab_owner[i] == it.owner &&
							(all || tab_rid[i] == it.req_id[14:0])) begin
						drop_slot(i);
						if (removed != RM_MAX)
							removed++;
					end
				res = mk_out(EV_CANCELLED, it.owner, it.req_id[14:0], '0, RTT_NONE, removed);
			end
		endcase
		return res;
	endfunction

	function automatic void add_row(pet_in_t stim, bit typed = 1'b0, pet_out_t want = '0);
		echo_row_t row;
		row.stim = stim;
		row.typed = typed;
		row.want = want;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Called at a clock edge; returns at the edge where the item is taken.
	task automatic push_item(input pet_in_t it, input bit typed = 1'b0,
			input pet_out_t want = '0);
		int gap;
		pet_out_t pred;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = echo_table_step(it);
		echo_results_due.insert(echo_results_due.size(), typed ? want : pred);
		n_sent++;
	endtask

	task automatic check_echo(input pet_out_t want, input pet_out_t got);
		if (got.event_res !== want.event_res) begin
			$error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
			mismatches++;
		end
		if (got.out_owner !== want.out_owner) begin
			$error("out_owner: expected %0d, got %0d", want.out_owner, got.out_owner);
			mismatches++;
		end
		if (got.out_req_id !== want.out_req_id) begin
			$error("out_req_id: expected %0d, got %0d", want.out_req_id, got.out_req_id);
			mismatches++;
		end
		if (got.out_seq !== want.out_seq) begin
			$error("out_seq: expected %0d, got %0d", want.out_seq, got.out_seq);
			mismatches++;
		end
		if (got.rtt_ms !== want.rtt_ms) begin
			$error("rtt_ms: expected %0d, got %0d", want.rtt_ms, got.rtt_ms);
			mismatches++;
		end
		if (got.removed_count !== want.removed_count) begin
			$error("removed_count: expected %0d, got %0d", want.removed_count,
				got.removed_count);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (echo_results_due.size() == 0) begin
				$error("result item with nothing due: event_res %0d", out_data.event_res);
				mismatches++;
			end else begin
				check_echo(echo_results_due.pop_front(), out_data);
			end
			n_checked++;
			ev_seen[out_data.event_res]++;
		end
	end

	// receiver: stall a random number of cycles after each result item
	int rx_hold = 0;
	always @(posedge clk or negedge arst_n) begin
		int draw;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold <= 0;
		end else if (out_valid && out_ready) begin
			draw = idle_on ? $urandom_range(0, 8) : 0;
			out_ready <= (draw == 0);
			rx_hold <= draw;
		end else if (!out_ready) begin
			if (rx_hold <= 1)
				out_ready <= 1'b1;
			rx_hold <= rx_hold - 1;
		end
	end

	initial begin
		int        pick;
		int        r;
		bit [31:0] ms_now;
		bit [7:0]  own;
		bit [15:0] rid;
		bit [21:0] tmo;
		pet_in_t   it;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(mk_in(FN_TICK, 8'd0, 16'd0, 22'd0, 32'd0, 16'd0), 1'b1,
			mk_out(EV_IDLE_TICK, '0, '0, '0, RTT_NONE, '0));
		add_row(mk_in(FN_REPLY, 8'd0, 16'd0, 22'd0, 32'd0, 16'hFFFF), 1'b1,
			mk_out(EV_UNMATCHED, '0, '0, 16'hFFFF, RTT_NONE, '0));
		add_row(mk_in(FN_START, 8'hFF, 16'h7FFF, 22'h3FFFFF, 32'hFFFF_FFFF, 16'd0), 1'b1,
			mk_out(EV_STARTED, 8'hFF, 15'h7FFF, 16'd1, RTT_NONE, '0));
		// zero timeout: never expires
		add_row(mk_in(FN_START, 8'd0, 16'd0, 22'd0, 32'd0, 16'd0), 1'b1,
			mk_out(EV_STARTED, 8'd0, 15'd0, 16'd2, RTT_NONE, '0));
		add_row(mk_in(FN_START, 8'd5, REQ_ALL, 22'd1, 32'd100, 16'd0));
		add_row(mk_in(FN_TICK, 8'd0, 16'd0, 22'd0, 32'd99, 16'd0));
		add_row(mk_in(FN_TICK, 8'd0, 16'd0, 22'd0, 32'd101, 16'd0));
		// rtt across the 2^32 wrap
		add_row(mk_in(FN_REPLY, 8'd0, 16'd0, 22'd0, 32'h10, 16'd1));
		for (int i = 0; i < TABLE_DEPTH - 1; i++)
			add_row(mk_in(FN_START, 8'd7, (i % 2) ? 16'd3 : 16'd9, 22'(50 + i),
				32'(200 + i), 16'd0));
		add_row(mk_in(FN_START, 8'hAA, 16'h1234, 22'd10, 32'd250, 16'd0), 1'b1,
			mk_out(EV_FULL, 8'hAA, 15'h1234, 16'd0, RTT_NONE, '0));
		add_row(mk_in(FN_CANCEL, 8'd7, 16'd3, 22'd0, 32'd260, 16'd0));
		// negative id other than all-ones matches on its low 15 bits
		add_row(mk_in(FN_CANCEL, 8'd7, 16'h8009, 22'd0, 32'd261, 16'd0));
		add_row(mk_in(FN_CANCEL, 8'd0, REQ_ALL, 22'd0, 32'd262, 16'd0));
		add_row(mk_in(FN_CANCEL, 8'h80, REQ_ALL, 22'd0, 32'd263, 16'd0), 1'b1,
			mk_out(EV_CANCELLED, 8'h80, 15'h7FFF, 16'd0, RTT_NONE, '0));
		foreach (dir_rows[i])
			push_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

		// random mix, mostly well-formed against live entries
		ms_now = 32'hFFFF_C000 + $urandom_range(0, 8000);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 100 == 0)
				idle_on <= ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 49) == 0)
				ms_now -= $urandom_range(0, 500);
			else
				ms_now += $urandom_range(0, 40);
			r = $urandom_range(0, 99);
			pick = pick_live();
			if (r < 5) begin
				it = mk_in(pet_func_t'($urandom_range(0, 3)), 8'($urandom),
					16'($urandom), 22'($urandom), $urandom, 16'($urandom));
			end else if (r < 45) begin
				own = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0: rid = 16'($urandom);
					1: rid = REQ_ALL;
					default: rid = 16'($urandom_range(0, 3));
				endcase
				case ($urandom_range(0, 7))
					0: tmo = '0;
					1: tmo = 22'($urandom);
					default: tmo = 22'($urandom_range(1, 300));
				endcase
				it = mk_in(FN_START, own, rid, tmo, ms_now, 16'($urandom));
			end else if (r < 70) begin
				it = mk_in(FN_REPLY, 8'($urandom), 16'($urandom), 22'($urandom), ms_now,
					(pick >= 0 && $urandom_range(0, 3) != 0) ? tab_seq[pick] : 16'($urandom));
			end else if (r < 90) begin
				it = mk_in(FN_TICK, 8'($urandom), 16'($urandom), 22'($urandom), ms_now,
					16'($urandom));
			end else if (pick >= 0) begin
				rid = $urandom_range(0, 1) ? REQ_ALL : {1'($urandom), tab_rid[pick]};
				it = mk_in(FN_CANCEL, tab_owner[pick], rid, 22'($urandom), ms_now,
					16'($urandom));
			end else begin
				it = mk_in(FN_CANCEL, 8'($urandom), 16'($urandom), 22'($urandom), ms_now,
					16'($urandom));
			end
			push_item(it);
		end

		// empty the table owner by owner
		idle_on <= 1'b0;
		pick = pick_live();
		while (pick >= 0) begin
			push_item(mk_in(FN_CANCEL, tab_owner[pick], REQ_ALL, '0, ms_now, '0));
			pick = pick_live();
		end
		in_valid <= 1'b0;

		while (echo_results_due.size() != 0)
			@(posedge clk);
		repeat (2 * TABLE_DEPTH) @(posedge clk);

		$display("%0d items sent, %0d results checked, sequence counter ended at %0d",
			n_sent, n_checked, seq_ctr);
		$display("events: start %0d full %0d reply %0d unmatched %0d timeout %0d",
			ev_seen[EV_STARTED], ev_seen[EV_FULL], ev_seen[EV_REPLIED],
			ev_seen[EV_UNMATCHED], ev_seen[EV_TIMED_OUT]);
		$display("events: idle tick %0d cancel %0d",
			ev_seen[EV_IDLE_TICK], ev_seen[EV_CANCELLED]);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: %0d result items still due", echo_results_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
design/pet_pkg.sv
design/pet_slot_mem.sv
design/pet_order.sv
design/pending_echo_tracker_top.sv
design/pet_checker.sv
bench/pending_echo_tracker_top_tb.sv
